// ===== src/blake2b_64_hash_defines.svh =====
// Assertion macros for the hash block.
`ifndef BLAKE2B_64_HASH_DEFINES_SVH
`define BLAKE2B_64_HASH_DEFINES_SVH

// Property that holds at every edge out of reset.
`define B2_ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error("lbl failed");

// Implication checked on the next edge.
`define B2_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lbl failed");

`endif

// ===== src/b2b_pkg.sv =====
`timescale 1ns / 1ps
package b2b_pkg;

   localparam int BlockWords = 16;
   localparam int Rounds = 12;
   localparam int QueueDepth = 2;

   typedef logic [63:0] word_type;

   // Operation passed from front to back.
   typedef enum logic [1:0] {
      OP_STORE = 2'd0,
      OP_FLUSH = 2'd1,
      OP_FINAL = 2'd2
   } op_type;

   typedef struct packed {
      op_type   op;
      word_type word;
      logic [3:0] nbytes;
   } cmd_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_ROUND = 2'd1,
      ST_DONE  = 2'd2,
      ST_OUT   = 2'd3
   } state_type;

   function automatic word_type iv(input logic [2:0] i);
      word_type r;
      case (i)
         3'd0: r = 64'h6a09e667f3bcc908;
         3'd1: r = 64'hbb67ae8584caa73b;
         3'd2: r = 64'h3c6ef372fe94f82b;
         3'd3: r = 64'ha54ff53a5f1d36f1;
         3'd4: r = 64'h510e527fade682d1;
         3'd5: r = 64'h9b05688c2b3e6c1f;
         3'd6: r = 64'h1f83d9abfb41bd6b;
         3'd7: r = 64'h5be0cd19137e2179;
         default: r = '0;
      endcase
      return r;
   endfunction

   function automatic logic [63:0] sigma(input logic [3:0] r);
      logic [63:0] s;
      case (r)
         4'd0, 4'd10: s = 64'hfedcba9876543210;
         4'd1, 4'd11: s = 64'h357b20c16df984ae;
         4'd2: s = 64'h491763eadf250c8b;
         4'd3: s = 64'h8f04a562ebcd1397;
         4'd4: s = 64'hd386cb1efa427509;
         4'd5: s = 64'h91ef57d438b0a6c2;
         4'd6: s = 64'hb8293670a4def15c;
         4'd7: s = 64'ha2684f05931ce7bd;
         4'd8: s = 64'h5a417d2c803b9ef6;
         4'd9: s = 64'h0dc3e9bf5167482a;
         default: s = '0;
      endcase
      return s;
   endfunction

   function automatic word_type rotr(input word_type v, input int n);
      return (v >> n) | (v << (64 - n));
   endfunction

   function automatic logic [255:0] gfun(input word_type a, input word_type b,
                                          input word_type c, input word_type d,
                                          input word_type x, input word_type y);
      word_type a1, b1, c1, d1;
      a1 = a + b + x;
      d1 = rotr(d ^ a1, 32);
      c1 = c + d1;
      b1 = rotr(b ^ c1, 24);
      a1 = a1 + b1 + y;
      d1 = rotr(d1 ^ a1, 16);
      c1 = c1 + d1;
      b1 = rotr(b1 ^ c1, 63);
      return {a1, b1, c1, d1};
   endfunction

endpackage

// ===== src/b2b_front.sv =====
`timescale 1ns / 1ps
// Turns each input transaction into one or two back-end commands.
module b2b_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  b2b_pkg::word_type      req_message_word,
   input  logic [3:0]             req_valid_bytes,
   input  logic                   req_end_of_message,
   output logic                   q_valid,
   input  logic                   q_stall,
   output b2b_pkg::cmd_type       q_cmd
);
   b2b_pkg::cmd_type q_ff [b2b_pkg::QueueDepth];
   b2b_pkg::cmd_type q_in [b2b_pkg::QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic pop;
   logic [3:0] nb;

   always_comb begin
      nb = (req_valid_bytes > 4'd8) ? 4'd8 : req_valid_bytes;
      pop = (cnt_ff != 2'd0) && !q_stall;
      req_stall = cnt_ff != 2'd0;
      q_valid = cnt_ff != 2'd0;
      q_cmd = q_ff[0];
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_ff - 2'd1;
      end
      if (req_valid && !req_stall) begin
         if (!req_end_of_message) begin
            q_in[0] = '{b2b_pkg::OP_STORE, req_message_word, 4'd8};
            cnt_in = 2'd1;
         end else if (nb == 4'd0) begin
            q_in[0] = '{b2b_pkg::OP_FINAL, req_message_word, 4'd0};
            cnt_in = 2'd1;
         end else begin
            q_in[0] = '{b2b_pkg::OP_STORE, req_message_word, nb};
            q_in[1] = '{b2b_pkg::OP_FINAL, req_message_word, 4'd0};
            cnt_in = 2'd2;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule

// ===== src/b2b_back.sv =====
`timescale 1ns / 1ps
// Block buffer plus a compression engine doing one half-round per cycle.
module b2b_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_stall,
   input  b2b_pkg::cmd_type       q_cmd,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output b2b_pkg::word_type      rsp_digest
);
   b2b_pkg::word_type h_ff [8], h_in [8];
   b2b_pkg::word_type m_ff [16], m_in [16];
   b2b_pkg::word_type v_ff [16], v_in [16];
   b2b_pkg::word_type cnt_ff, cnt_in, dig_ff, dig_in;
   logic [4:0] fill_ff, fill_in;
   logic [4:0] step_ff, step_in;
   logic fin_ff, fin_in;
   b2b_pkg::state_type st_ff, st_in;
   logic [63:0] s;
   logic [255:0] g [4];
   b2b_pkg::word_type w;

   always_comb begin
      s = b2b_pkg::sigma(step_ff[4:1]);
      for (int k = 0; k < 4; k++) begin
         if (!step_ff[0])
            g[k] = b2b_pkg::gfun(v_ff[k], v_ff[k+4], v_ff[k+8], v_ff[k+12],
                                 m_ff[s[8*k +: 4]], m_ff[s[8*k+4 +: 4]]);
         else
            g[k] = b2b_pkg::gfun(v_ff[k], v_ff[4+((k+1)%4)], v_ff[8+((k+2)%4)],
                                 v_ff[12+((k+3)%4)], m_ff[s[32+8*k +: 4]],
                                 m_ff[s[36+8*k +: 4]]);
      end
   end

   always_comb begin
      h_in = h_ff; m_in = m_ff; v_in = v_ff; cnt_in = cnt_ff; dig_in = dig_ff;
      fill_in = fill_ff; step_in = step_ff; fin_in = fin_ff;
      st_in = st_ff;
      w = '0;
      q_stall = 1'b1;
      rsp_valid = st_ff == b2b_pkg::ST_OUT;
      rsp_digest = dig_ff;
      case (st_ff)
         b2b_pkg::ST_IDLE: begin
            q_stall = 1'b0;
            if (q_valid) begin
               if (q_cmd.op == b2b_pkg::OP_STORE &&
                   fill_ff == 5'(b2b_pkg::BlockWords)) begin
                  q_stall = 1'b1;
                  fin_in = 1'b0;
                  st_in = b2b_pkg::ST_ROUND;
               end else if (q_cmd.op == b2b_pkg::OP_STORE) begin
                  for (int b = 0; b < 8; b++)
                     w[8*b +: 8] = (b < q_cmd.nbytes) ? q_cmd.word[8*b +: 8] : 8'd0;
                  m_in[fill_ff[3:0]] = w;
                  fill_in = fill_ff + 5'd1;
                  cnt_in = cnt_ff + {60'd0, q_cmd.nbytes};
               end else begin
                  fin_in = 1'b1;
                  st_in = b2b_pkg::ST_ROUND;
               end
               if (st_in == b2b_pkg::ST_ROUND) begin
                  for (int i = 0; i < 8; i++) begin
                     v_in[i] = h_ff[i];
                     v_in[i+8] = b2b_pkg::iv(3'(i));
                  end
                  v_in[12] = v_in[12] ^ cnt_ff;
                  if (fin_in) v_in[14] = ~v_in[14];
                  step_in = '0;
               end
            end
         end
         b2b_pkg::ST_ROUND: begin
            for (int k = 0; k < 4; k++) begin
               if (!step_ff[0]) begin
                  {v_in[k], v_in[k+4], v_in[k+8], v_in[k+12]} = g[k];
               end else begin
                  {v_in[k], v_in[4+((k+1)%4)], v_in[8+((k+2)%4)],
                   v_in[12+((k+3)%4)]} = g[k];
               end
            end
            step_in = step_ff + 5'd1;
            if (step_ff == 5'(2*b2b_pkg::Rounds-1)) st_in = b2b_pkg::ST_DONE;
         end
         b2b_pkg::ST_DONE: begin
            for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] ^ v_ff[i] ^ v_ff[i+8];
            for (int i = 0; i < 16; i++) m_in[i] = '0;
            fill_in = '0;
            if (fin_ff) begin
               dig_in = h_in[0];
               for (int i = 0; i < 8; i++) h_in[i] = b2b_pkg::iv(3'(i));
               h_in[0] = h_in[0] ^ 64'h01010008;
               cnt_in = '0;
               st_in = b2b_pkg::ST_OUT;
            end else begin
               st_in = b2b_pkg::ST_IDLE;
            end
         end
         b2b_pkg::ST_OUT: begin
            if (!rsp_stall) st_in = b2b_pkg::ST_IDLE;
         end
         default: st_in = b2b_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in; dig_ff <= dig_in; step_ff <= step_in; fin_ff <= fin_in;
      if (reset) begin
         st_ff <= b2b_pkg::ST_IDLE;
         fill_ff <= '0;
         cnt_ff <= '0;
         h_ff[0] <= b2b_pkg::iv(3'd0) ^ 64'h01010008;
         for (int i = 1; i < 8; i++) h_ff[i] <= b2b_pkg::iv(3'(i));
         for (int i = 0; i < 16; i++) m_ff[i] <= '0;
      end else begin
         st_ff <= st_in; fill_ff <= fill_in; cnt_ff <= cnt_in;
         h_ff <= h_in; m_ff <= m_in;
      end
   end
endmodule

// ===== src/blake2b_64_hash.sv =====
`timescale 1ns / 1ps
// BLAKE2b, unkeyed, 8-byte digest. Message words of eight bytes stream in,
// each only once the queue has handed the last one to the buffer. Every
// 128-byte block is compressed by 24 half-rounds of four G units, with one
// setup and one finalize step, while the input stalls; the last word then
// takes one more compression, after which the digest holds until taken.
module blake2b_64_hash (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [63:0] req_message_word,
   input  logic [3:0]  req_valid_bytes,
   input  logic        req_end_of_message,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_digest
);
`include "blake2b_64_hash_defines.svh"
   logic q_valid, q_stall;
   b2b_pkg::cmd_type q_cmd;

   b2b_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_message_word,
      .req_valid_bytes, .req_end_of_message, .q_valid, .q_stall, .q_cmd);

   b2b_back u_back (
      .clock, .reset, .q_valid, .q_stall, .q_cmd, .rsp_valid, .rsp_stall,
      .rsp_digest);

   `B2_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_digest))
   `B2_ASSERT_ALWAYS(a_stall_when_queued, clock, reset, !q_valid || req_stall)
endmodule

// ===== sim/tb_blake2b_64_hash.sv =====
`timescale 1ns / 1ps
module tb_blake2b_64_hash;

   typedef struct {
      logic [63:0] word;
      logic [3:0]  nbytes;
      logic        last;
   } msg_word_type;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [63:0] req_message_word;
   logic [3:0]  req_valid_bytes;
   logic        req_end_of_message;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [63:0] rsp_digest;

   blake2b_64_hash DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_message_word(req_message_word),
      .req_valid_bytes(req_valid_bytes),
      .req_end_of_message(req_end_of_message),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_digest(rsp_digest)
   );

   localparam logic [63:0] IV0 = 64'h6a09e667f3bcc908;
   localparam logic [63:0] IV1 = 64'hbb67ae8584caa73b;
   localparam logic [63:0] IV2 = 64'h3c6ef372fe94f82b;
   localparam logic [63:0] IV3 = 64'ha54ff53a5f1d36f1;
   localparam logic [63:0] IV4 = 64'h510e527fade682d1;
   localparam logic [63:0] IV5 = 64'h9b05688c2b3e6c1f;
   localparam logic [63:0] IV6 = 64'h1f83d9abfb41bd6b;
   localparam logic [63:0] IV7 = 64'h5be0cd19137e2179;
   localparam logic [63:0] PARAM_BLOCK = 64'h0000_0000_0101_0008;
   localparam int TIMEOUT_CYCLES = 400000;
   localparam int LONG_HOLD = 400;

   logic [63:0] hash_h[8];
   logic [63:0] msg_blk[16];
   logic [63:0] v[16];
   logic [63:0] msg_len;
   int unsigned blk_fill;
   logic [3:0] perm[12][16];

   msg_word_type pending_words[$];
   logic [63:0] expected_digests[$];
   int unsigned idle_in, idle_out;
   bit          hold_rsp_req, drain_req;
   int          hold_count;
   int          cycles;
   int          errors;

   function automatic logic [63:0] rot(logic [63:0] x, int n);
      return (x >> n) | (x << (64 - n));
   endfunction

   function automatic logic [63:0] init_iv(int i);
      case (i)
         0: return IV0;
         1: return IV1;
         2: return IV2;
         3: return IV3;
         4: return IV4;
         5: return IV5;
         6: return IV6;
         default: return IV7;
      endcase
   endfunction

   task automatic mix(int a, int b, int c, int d, logic [63:0] x, logic [63:0] y);
      v[a] = v[a] + v[b] + x;
      v[d] = rot(v[d] ^ v[a], 32);
      v[c] = v[c] + v[d];
      v[b] = rot(v[b] ^ v[c], 24);
      v[a] = v[a] + v[b] + y;
      v[d] = rot(v[d] ^ v[a], 16);
      v[c] = v[c] + v[d];
      v[b] = rot(v[b] ^ v[c], 63);
   endtask

   task automatic compress(bit final_blk);
      for (int i = 0; i < 8; i++) begin
         v[i] = hash_h[i];
         v[i+8] = init_iv(i);
      end
      v[12] ^= msg_len;
      if (final_blk) v[14] = ~v[14];
      for (int r = 0; r < 12; r++) begin
         mix(0, 4, 8, 12, msg_blk[perm[r][0]], msg_blk[perm[r][1]]);
         mix(1, 5, 9, 13, msg_blk[perm[r][2]], msg_blk[perm[r][3]]);
         mix(2, 6, 10, 14, msg_blk[perm[r][4]], msg_blk[perm[r][5]]);
         mix(3, 7, 11, 15, msg_blk[perm[r][6]], msg_blk[perm[r][7]]);
         mix(0, 5, 10, 15, msg_blk[perm[r][8]], msg_blk[perm[r][9]]);
         mix(1, 6, 11, 12, msg_blk[perm[r][10]], msg_blk[perm[r][11]]);
         mix(2, 7, 8, 13, msg_blk[perm[r][12]], msg_blk[perm[r][13]]);
         mix(3, 4, 9, 14, msg_blk[perm[r][14]], msg_blk[perm[r][15]]);
      end
      for (int i = 0; i < 8; i++) hash_h[i] ^= v[i] ^ v[i+8];
      for (int i = 0; i < 16; i++) msg_blk[i] = '0;
      blk_fill = 0;
   endtask

   task automatic hash_restart();
      for (int i = 0; i < 8; i++) hash_h[i] = init_iv(i);
      hash_h[0] ^= PARAM_BLOCK;
      for (int i = 0; i < 16; i++) msg_blk[i] = '0;
      msg_len = '0;
      blk_fill = 0;
   endtask

   task automatic absorb_word(msg_word_type t);
      logic [63:0] w;
      int n;
      w = t.word;
      n = t.nbytes;
      if (!t.last) begin
         if (blk_fill >= 16) compress(0);
         msg_blk[blk_fill[3:0]] = w;
         blk_fill++;
         msg_len += 64'd8;
      end else begin
         if (n > 8) n = 8;
         if (n > 0) begin
            if (blk_fill >= 16) compress(0);
            if (n < 8) w &= (64'd1 << (8 * n)) - 64'd1;
            msg_blk[blk_fill[3:0]] = w;
            blk_fill++;
            msg_len += 64'(n);
         end
         compress(1);
         expected_digests.push_back(hash_h[0]);
         hash_restart();
      end
   endtask

   task automatic queue_word(logic [63:0] w, logic [3:0] n, logic last);
      msg_word_type t;
      t.word = w;
      t.nbytes = n;
      t.last = last;
      pending_words.push_back(t);
   endtask

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic queue_message(int nfull, logic [3:0] n);
      for (int i = 0; i < nfull; i++) queue_word(rand64(), 4'($urandom), 1'b0);
      queue_word(rand64(), n, 1'b1);
   endtask

   function automatic int pick_len();
      int k;
      k = $urandom_range(0, 9);
      if (k < 5) return $urandom_range(0, 6);
      if (k < 8) return 16 * $urandom_range(1, 3) + $urandom_range(0, 1) - 1 + 1;
      return $urandom_range(0, 60);
   endfunction

   always begin
      clock = 1'b0;
      #10;
      clock = 1'b1;
      #10;
   end

   // driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || !req_stall) begin
         if (req_valid) begin
            absorb_word(pending_words.pop_front());
         end
         if (pending_words.size() > 0 && !drain_req &&
             $urandom_range(0, 99) >= idle_in) begin
            req_valid <= 1'b1;
            req_message_word <= pending_words[0].word;
            req_valid_bytes <= pending_words[0].nbytes;
            req_end_of_message <= pending_words[0].last;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_count <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_digests.size() == 0) begin
               $error("digest: unexpected transaction, actual %h", rsp_digest);
               errors++;
            end else begin
               if (rsp_digest !== expected_digests[0]) begin
                  $error("digest: expected %h actual %h", expected_digests[0], rsp_digest);
                  errors++;
               end
               void'(expected_digests.pop_front());
            end
         end
         if (hold_rsp_req && hold_count == 0) begin
            hold_count <= LONG_HOLD;
            rsp_stall <= 1'b1;
         end else if (hold_count > 1) begin
            hold_count <= hold_count - 1;
            rsp_stall <= 1'b1;
         end else begin
            hold_count <= 0;
            rsp_stall <= ($urandom_range(0, 99) < idle_out);
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > TIMEOUT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic wait_empty();
      while (pending_words.size() > 0 || req_valid || expected_digests.size() > 0)
         @(posedge clock);
   endtask

   initial begin
      logic [3:0] pr[12][16];
      int len;
      pr[0]  = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11, 12, 13, 14, 15};
      pr[1]  = '{14, 10, 4, 8, 9, 15, 13, 6, 1, 12, 0, 2, 11, 7, 5, 3};
      pr[2]  = '{11, 8, 12, 0, 5, 2, 15, 13, 10, 14, 3, 6, 7, 1, 9, 4};
      pr[3]  = '{7, 9, 3, 1, 13, 12, 11, 14, 2, 6, 5, 10, 4, 0, 15, 8};
      pr[4]  = '{9, 0, 5, 7, 2, 4, 10, 15, 14, 1, 11, 12, 6, 8, 3, 13};
      pr[5]  = '{2, 12, 6, 10, 0, 11, 8, 3, 4, 13, 7, 5, 15, 14, 1, 9};
      pr[6]  = '{12, 5, 1, 15, 14, 13, 4, 10, 0, 7, 6, 3, 9, 2, 8, 11};
      pr[7]  = '{13, 11, 7, 14, 12, 1, 3, 9, 5, 0, 15, 4, 8, 6, 2, 10};
      pr[8]  = '{6, 15, 14, 9, 11, 3, 0, 8, 12, 2, 13, 7, 1, 4, 10, 5};
      pr[9]  = '{10, 2, 8, 4, 7, 6, 1, 5, 15, 11, 9, 14, 3, 12, 13, 0};
      pr[10] = pr[0];
      pr[11] = pr[1];
      perm = pr;
      errors = 0;
      cycles = 0;
      hold_rsp_req = 1'b0;
      drain_req = 1'b0;
      idle_in = 32;
      idle_out = 53;
      req_valid = 1'b0;
      req_message_word = '0;
      req_valid_bytes = '0;
      req_end_of_message = 1'b0;
      rsp_stall = 1'b0;
      hash_restart();
      reset = 1'b1;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: empty, extremes, sample byte counts, block boundaries
      queue_word('0, 4'd0, 1'b1);
      queue_word('1, 4'd8, 1'b1);
      queue_word('0, 4'd8, 1'b1);
      queue_word('1, 4'd15, 1'b1);
      queue_word(rand64(), 4'd1, 1'b1);
      queue_word(rand64(), 4'd7, 1'b1);
      queue_word('1, 4'd9, 1'b0);
      queue_word(rand64(), 4'd3, 1'b1);
      queue_message(16, 4'd0);
      queue_message(15, 4'd0);
      queue_message(16, 4'd5);
      wait_empty();

      for (int ph = 0; ph < 3; ph++) begin
         if (ph == 1) begin
            idle_in = 53;
            idle_out = 32;
         end else if (ph == 2) begin
            idle_in = 0;
            idle_out = 0;
         end
         len = 0;
         while (len < 620) begin
            int nf;
            nf = pick_len();
            queue_message(nf, 4'($urandom_range(0, 15)));
            len += nf + 1;
         end
         if (ph == 0) begin
            repeat (20) @(posedge clock);
            hold_rsp_req <= 1'b1;
            @(posedge clock);
            hold_rsp_req <= 1'b0;
         end
         if (ph == 1) begin
            while (pending_words.size() > 300) @(posedge clock);
            drain_req <= 1'b1;
            while (req_valid || expected_digests.size() > 0) @(posedge clock);
            drain_req <= 1'b0;
         end
         wait_empty();
      end

      repeat (100) @(posedge clock);
      if (errors == 0 && expected_digests.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
